// ----- hw/rtl/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, widths and codes for the four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int TABLE_PAGES     = 8;
   localparam int WORDS_PER_PAGE  = 512;
   localparam int STORE_WORDS     = TABLE_PAGES * WORDS_PER_PAGE;
   localparam int PAGE_BITS       = $clog2(TABLE_PAGES);
   localparam int WORD_IDX_BITS   = $clog2(WORDS_PER_PAGE);
   localparam int STORE_ADDR_BITS = PAGE_BITS + WORD_IDX_BITS;

   localparam int VA_BITS    = 64;
   localparam int PA_BITS    = 52;
   localparam int WORD_BITS  = 64;
   localparam int TIDX_BITS  = 12;
   localparam int ROOT_BITS  = 3;
   localparam int KIND_BITS  = 2;
   localparam int LEVEL_BITS = 2;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_HUGE    = 7;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_4K = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_2M = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_1G = 2'd2;

   localparam logic [LEVEL_BITS-1:0] LEVEL_PML4 = 2'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_PDPT = 2'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_PD   = 2'd2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_PT   = 2'd3;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } ptw_state_type;

   typedef struct packed {
      logic                       rd_en;
      logic                       wr_en;
      logic [STORE_ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0]       wr_data;
   } ptw_mem_req_type;

   function automatic logic [WORD_IDX_BITS-1:0] level_index(
      input logic [VA_BITS-1:0]    virt,
      input logic [LEVEL_BITS-1:0] level
   );
      logic [WORD_IDX_BITS-1:0] idx;
      unique case (level)
         LEVEL_PML4: idx = virt[47:39];
         LEVEL_PDPT: idx = virt[38:30];
         LEVEL_PD:   idx = virt[29:21];
         default:    idx = virt[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ----- hw/rtl/ptw_req_if.sv -----
// ----------------------------------------------------------------------------
// ptw_req_if
// Request channel: table word writes and translate commands.
// ----------------------------------------------------------------------------
interface ptw_req_if import ptw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [VA_BITS-1:0]   virt_addr;
   logic [TIDX_BITS-1:0] table_index;
   logic [WORD_BITS-1:0] table_word;

   modport source (output valid, command, virt_addr, table_index, table_word, input ready);
   modport sink (input valid, command, virt_addr, table_index, table_word, output ready);
endinterface

// ----- hw/rtl/ptw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ptw_rsp_if
// Response channel: one translation result per translate command.
// ----------------------------------------------------------------------------
interface ptw_rsp_if import ptw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PA_BITS-1:0]   phys_addr;
   logic                 unmapped;
   logic [KIND_BITS-1:0] page_kind;

   modport source (output valid, phys_addr, unmapped, page_kind, input ready);
   modport sink (input valid, phys_addr, unmapped, page_kind, output ready);
endinterface

// ----- hw/rtl/ptw_store.sv -----
// ----------------------------------------------------------------------------
// ptw_store
// Single-port page-table word memory with registered read and a zeroing
// sweep after reset.
// ----------------------------------------------------------------------------
module ptw_store import ptw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ptw_mem_req_type      mem_req,
   output logic [WORD_BITS-1:0] rd_data,
   output logic                 clearing
);

   logic [WORD_BITS-1:0]       mem [STORE_WORDS];
   logic [WORD_BITS-1:0]       rd_data_ff;
   logic [STORE_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                       clearing_ff, clearing_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_ADDR_BITS'(STORE_WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

// ----- hw/rtl/ptw_walk.sv -----
// ----------------------------------------------------------------------------
// ptw_walk
// Walk sequencer: issues one table read per level, decodes each entry as it
// returns and loads the response register.
// ----------------------------------------------------------------------------
module ptw_walk import ptw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ROOT_BITS-1:0] root_page,
   input  logic                 clearing,
   input  logic [WORD_BITS-1:0] rd_data,
   output ptw_mem_req_type      mem_req,
   ptw_req_if.sink              req_chan,
   ptw_rsp_if.source            rsp_chan
);

   ptw_state_type         state_ff, state_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [VA_BITS-1:0]    virt_ff, virt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PA_BITS-1:0]    phys_ff, phys_in;
   logic                  unmapped_ff, unmapped_in;
   logic [KIND_BITS-1:0]  kind_ff, kind_in;

   logic                  req_accept;
   logic                  slot_free;
   logic                  present;
   logic                  huge;
   logic                  walk_end;
   logic [PAGE_BITS-1:0]  next_page;

   assign req_chan.ready = (state_ff == ST_IDLE) && !clearing;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign present   = rd_data[BIT_PRESENT];
   assign huge      = rd_data[BIT_HUGE];
   assign next_page = PAGE_BITS'(rd_data[51:12]);
   assign walk_end  = !present || (level_ff == LEVEL_PT)
                      || (huge && ((level_ff == LEVEL_PDPT) || (level_ff == LEVEL_PD)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_chan.command == CMD_TRANSLATE)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_end && slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_req      = '0;
      level_in     = level_ff;
      virt_in      = virt_ff;
      rsp_valid_in = rsp_valid_ff;
      phys_in      = phys_ff;
      unmapped_in  = unmapped_ff;
      kind_in      = kind_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.command == CMD_TRANSLATE) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = {PAGE_BITS'(root_page),
                                   level_index(req_chan.virt_addr, LEVEL_PML4)};
                  virt_in       = req_chan.virt_addr;
                  level_in      = LEVEL_PML4;
               end else begin
                  mem_req.wr_en   = 32'(req_chan.table_index) < STORE_WORDS;
                  mem_req.addr    = STORE_ADDR_BITS'(req_chan.table_index);
                  mem_req.wr_data = req_chan.table_word;
               end
            end
         end
         ST_WALK: begin
            if (!walk_end) begin
               mem_req.rd_en = 1'b1;
               mem_req.addr  = {next_page, level_index(virt_ff, level_ff + 1'b1)};
               level_in      = level_ff + 1'b1;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (!present) begin
                  phys_in     = '0;
                  unmapped_in = 1'b1;
                  kind_in     = KIND_4K;
               end else if (level_ff == LEVEL_PDPT) begin
                  phys_in     = {rd_data[51:30], virt_ff[29:0]};
                  unmapped_in = 1'b0;
                  kind_in     = KIND_1G;
               end else if (level_ff == LEVEL_PD) begin
                  phys_in     = {rd_data[51:21], virt_ff[20:0]};
                  unmapped_in = 1'b0;
                  kind_in     = KIND_2M;
               end else begin
                  phys_in     = {rd_data[51:12], virt_ff[11:0]};
                  unmapped_in = 1'b0;
                  kind_in     = KIND_4K;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= LEVEL_PML4;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      virt_ff     <= virt_in;
      phys_ff     <= phys_in;
      unmapped_ff <= unmapped_in;
      kind_ff     <= kind_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.phys_addr = phys_ff;
   assign rsp_chan.unmapped  = unmapped_ff;
   assign rsp_chan.page_kind = kind_ff;

endmodule

// ----- hw/rtl/four_level_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Translates virtual addresses through four levels of page tables kept in
// an on-chip table store; table words are loaded through the request channel.
// ----------------------------------------------------------------------------
// A translate item issues its first table read on accept, then one read per
// further level from the single-port store, whose read data is registered.
// The result sits in an output register, so a new item is taken while it
// waits. After reset the store is zeroed one word a cycle, all 4096 words,
// during which no item is accepted; csr writes are taken at any time.
// ----------------------------------------------------------------------------
module four_level_page_table_walker import ptw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [ROOT_BITS-1:0] csr_wr_data,
   ptw_req_if.sink              req_chan,
   ptw_rsp_if.source            rsp_chan
);

   logic [ROOT_BITS-1:0] root_page_ff, root_page_in;
   ptw_mem_req_type      mem_req;
   logic [WORD_BITS-1:0] rd_data;
   logic                 clearing;

   assign root_page_in = csr_wr_en ? csr_wr_data : root_page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_page_ff <= '0;
      end else begin
         root_page_ff <= root_page_in;
      end
   end

   ptw_store u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   ptw_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .root_page (root_page_ff),
      .clearing  (clearing),
      .rd_data   (rd_data),
      .mem_req   (mem_req),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

endmodule
